### hdl/sswc_pkg.sv
// Package for the sleep-stage window classifier.
// Holds sizing constants, register indexes, stage codes and reset values.
// No dependencies; imported by sleep_stage_window_classifier_top.
`default_nettype none

package sswc_pkg;

    // Mux and frame sequencing
    localparam int CHANNELS    = 8;
    localparam int FRAME_WRAP  = 170;
    localparam int FRAME_READY = 150;
    localparam int CHAN_W      = $clog2(CHANNELS);

    // Field widths
    localparam int FRAME_W = 8;
    localparam int TICK_W  = 20;
    localparam int PCT_W   = 8;
    localparam int MOVE_W  = 16;
    localparam int BEAT_W  = 32;
    localparam int INC_W   = 8;
    localparam int STAGE_W = 2;
    localparam int PROD_W  = BEAT_W + PCT_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = TICK_W;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_WAKE_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_DROP_PCT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAKE_RISE_PCT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEEP_PCT        = 3'd4;

    // Register reset values
    localparam logic [TICK_W-1:0] RST_WINDOW_TICKS    = 20'd6000;
    localparam logic [PCT_W-1:0]  RST_MOVE_WAKE_LIMIT = 8'd3;
    localparam logic [PCT_W-1:0]  RST_LIGHT_DROP_PCT  = 8'd98;
    localparam logic [PCT_W-1:0]  RST_WAKE_RISE_PCT   = 8'd102;
    localparam logic [PCT_W-1:0]  RST_DEEP_PCT        = 8'd94;

    // Sleep stage codes
    localparam logic [STAGE_W-1:0] STAGE_IN_BED = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_WAKE   = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_LIGHT  = 2'd2;
    localparam logic [STAGE_W-1:0] STAGE_DEEP   = 2'd3;

endpackage

`default_nettype wire

### hdl/sleep_stage_window_classifier_top.sv
// Top level of the sleep-stage window classifier.
// Depends on sswc_pkg for constants, register indexes and stage codes.
`default_nettype none

// Usage
// - Input channel (i_in_valid / o_in_ready): one transaction per 10 ms tick,
//   carrying restart, body_move and beat_increment.
// - Output channel (o_out_valid / i_out_ready): one result transaction per
//   input transaction, in order.
// - Config channel (i_cfg_valid / o_cfg_ready): always ready; index picks
//   window_ticks, move_wake_limit, light_drop_pct, wake_rise_pct or deep_pct.
//   Write only while no transaction is in flight.
// - Two register stages: the first steps the mux channel, frame counter,
//   tick counter and saturating move/beat sums; the second runs the stage
//   machine (percentage compares of 100*beats against pct*baseline) and
//   holds the result. o_out_valid rises once an accepted input transaction
//   has passed the first-stage register into the result register.
// - Throughput is one tick per cycle while the receiver does not stall; the
//   limit is the stage/baseline loop held in the second-stage registers.
// - When the receiver stalls, the result register holds and the first stage
//   takes transactions until it is full, then o_in_ready drops.
// - Synchronous reset clears both stages, zeroes counters, sums, baseline
//   and last-window values, sets the stage to wake and reloads the
//   register defaults.
module sleep_stage_window_classifier_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Input channel
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire                          i_restart,
    input  wire                          i_body_move,
    input  wire  [sswc_pkg::INC_W-1:0]   i_beat_increment,
    // Output channel
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [sswc_pkg::CHAN_W-1:0]  o_sampled_channel,
    output logic [sswc_pkg::FRAME_W-1:0] o_frame_index,
    output logic                         o_collect_set,
    output logic                         o_window_done,
    output logic [sswc_pkg::STAGE_W-1:0] o_sleep_stage,
    output logic [sswc_pkg::MOVE_W-1:0]  o_window_moves,
    output logic [sswc_pkg::BEAT_W-1:0]  o_window_beats,
    // Config channel
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [sswc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [sswc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sswc_pkg::*;

    localparam logic [CHAN_W-1:0]  CHAN_LAST  = CHAN_W'(CHANNELS - 1);
    localparam logic [FRAME_W-1:0] FRAME_WRAP_V  = FRAME_W'(FRAME_WRAP);
    localparam logic [FRAME_W-1:0] FRAME_READY_V = FRAME_W'(FRAME_READY);
    localparam logic [MOVE_W-1:0]  MOVE_MAX  = '1;
    localparam logic [BEAT_W-1:0]  BEAT_MAX  = '1;

    // Configuration registers
    logic [TICK_W-1:0] r_window_ticks;
    logic [PCT_W-1:0]  r_move_limit;
    logic [PCT_W-1:0]  r_light_pct;
    logic [PCT_W-1:0]  r_rise_pct;
    logic [PCT_W-1:0]  r_deep_pct;

    // First-stage state
    logic [CHAN_W-1:0]  r_chan;
    logic [FRAME_W-1:0] r_frame;
    logic [TICK_W-1:0]  r_tick;
    logic [MOVE_W-1:0]  r_move_acc;
    logic [BEAT_W-1:0]  r_beat_acc;

    // First-stage pipeline register
    logic               r_a_valid;
    logic [CHAN_W-1:0]  r_a_chan;
    logic [FRAME_W-1:0] r_a_frame;
    logic               r_a_collect;
    logic               r_a_done;
    logic               r_a_restart;
    logic [MOVE_W-1:0]  r_a_moves;
    logic [BEAT_W-1:0]  r_a_beats;

    // Second-stage state and result register
    logic               r_out_valid;
    logic [CHAN_W-1:0]  r_o_chan;
    logic [FRAME_W-1:0] r_o_frame;
    logic               r_o_collect;
    logic               r_o_done;
    logic [STAGE_W-1:0] r_stage;
    logic [BEAT_W-1:0]  r_baseline;
    logic [MOVE_W-1:0]  r_last_moves;
    logic [BEAT_W-1:0]  r_last_beats;

    // Handshake control
    logic in_fire;
    logic out_load;

    assign out_load   = r_a_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_a_valid || out_load;
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Capture configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks <= RST_WINDOW_TICKS;
            r_move_limit   <= RST_MOVE_WAKE_LIMIT;
            r_light_pct    <= RST_LIGHT_DROP_PCT;
            r_rise_pct     <= RST_WAKE_RISE_PCT;
            r_deep_pct     <= RST_DEEP_PCT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_WINDOW_TICKS:    r_window_ticks <= i_cfg_data;
                REG_MOVE_WAKE_LIMIT: r_move_limit   <= i_cfg_data[PCT_W-1:0];
                REG_LIGHT_DROP_PCT:  r_light_pct    <= i_cfg_data[PCT_W-1:0];
                REG_WAKE_RISE_PCT:   r_rise_pct     <= i_cfg_data[PCT_W-1:0];
                REG_DEEP_PCT:        r_deep_pct     <= i_cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- First stage: counters and window sums ----------------
    logic               chan_wrap;
    logic [CHAN_W-1:0]  n_chan;
    logic [FRAME_W-1:0] frame_inc;
    logic [FRAME_W-1:0] n_frame;
    logic               collect;
    logic [TICK_W-1:0]  tick_base;
    logic [MOVE_W-1:0]  move_base;
    logic [BEAT_W-1:0]  beat_base;
    logic [MOVE_W-1:0]  move_sum;
    logic [BEAT_W:0]    beat_wide;
    logic [BEAT_W-1:0]  beat_sum;
    logic               close;

    // Step channel and frame counter
    always_comb begin
        chan_wrap = (r_chan == CHAN_LAST);
        n_chan    = chan_wrap ? '0 : r_chan + 1'b1;
        frame_inc = r_frame + 1'b1;
        collect   = chan_wrap && (frame_inc >= FRAME_READY_V);
        if (!chan_wrap) begin
            n_frame = r_frame;
        end else if (frame_inc == FRAME_WRAP_V) begin
            n_frame = '0;
        end else begin
            n_frame = frame_inc;
        end
    end

    // Apply restart, add this tick, saturate, check window end
    always_comb begin
        tick_base = i_restart ? '0 : r_tick;
        move_base = i_restart ? '0 : r_move_acc;
        beat_base = i_restart ? '0 : r_beat_acc;
        move_sum  = (i_body_move && move_base != MOVE_MAX) ? move_base + 1'b1 : move_base;
        beat_wide = {1'b0, beat_base} + (BEAT_W + 1)'(i_beat_increment);
        beat_sum  = beat_wide[BEAT_W] ? BEAT_MAX : beat_wide[BEAT_W-1:0];
        close     = (tick_base == r_window_ticks);
    end

    // Advance first-stage state on each input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan     <= '0;
            r_frame    <= '0;
            r_tick     <= '0;
            r_move_acc <= '0;
            r_beat_acc <= '0;
        end else if (in_fire) begin
            r_chan  <= n_chan;
            r_frame <= n_frame;
            if (close) begin
                r_tick     <= '0;
                r_move_acc <= '0;
                r_beat_acc <= '0;
            end else begin
                r_tick     <= tick_base + 1'b1;
                r_move_acc <= move_sum;
                r_beat_acc <= beat_sum;
            end
        end
    end

    // Hold the tick's data for the second stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_fire) begin
            r_a_valid <= 1'b1;
        end else if (out_load) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_chan    <= r_chan;
            r_a_frame   <= n_frame;
            r_a_collect <= collect;
            r_a_done    <= close;
            r_a_restart <= i_restart;
            r_a_moves   <= move_sum;
            r_a_beats   <= beat_sum;
        end
    end

    // ---------------- Second stage: stage machine ----------------
    logic [STAGE_W-1:0] stage_base;
    logic [PROD_W-1:0]  beats_x100;
    logic [PROD_W-1:0]  light_lim;
    logic [PROD_W-1:0]  rise_lim;
    logic [PROD_W-1:0]  deep_lim;
    logic               many;
    logic [STAGE_W-1:0] n_stage;
    logic               take_base;

    // Scale beats by 100 and baseline by each percentage
    always_comb begin
        beats_x100 = (PROD_W'(r_a_beats) << 6) + (PROD_W'(r_a_beats) << 5)
                   + (PROD_W'(r_a_beats) << 2);
        light_lim  = PROD_W'(r_baseline) * PROD_W'(r_light_pct);
        rise_lim   = PROD_W'(r_baseline) * PROD_W'(r_rise_pct);
        deep_lim   = PROD_W'(r_baseline) * PROD_W'(r_deep_pct);
        many       = (r_a_moves >= MOVE_W'(r_move_limit));
    end

    // Decide the next stage; restart forces wake before classifying
    always_comb begin
        stage_base = r_a_restart ? STAGE_WAKE : r_stage;
        n_stage    = stage_base;
        take_base  = 1'b0;
        if (r_a_done) begin
            case (stage_base)
                STAGE_WAKE: begin
                    if (!many && beats_x100 < light_lim) begin
                        n_stage = STAGE_LIGHT;
                    end else begin
                        take_base = 1'b1;
                    end
                end
                STAGE_LIGHT: begin
                    if (many || beats_x100 > rise_lim) begin
                        n_stage = STAGE_WAKE;
                    end else if (beats_x100 < deep_lim) begin
                        n_stage = STAGE_DEEP;
                    end
                end
                STAGE_DEEP: begin
                    if (many) begin
                        n_stage = STAGE_WAKE;
                    end else if (r_a_moves != '0 || beats_x100 > deep_lim) begin
                        n_stage = STAGE_LIGHT;
                    end
                end
                default: begin
                    n_stage   = STAGE_WAKE;
                    take_base = 1'b1;
                end
            endcase
        end
    end

    // Update stage, baseline and last-window values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage      <= STAGE_WAKE;
            r_baseline   <= '0;
            r_last_moves <= '0;
            r_last_beats <= '0;
        end else if (out_load) begin
            r_stage <= n_stage;
            if (take_base) begin
                r_baseline <= r_a_beats;
            end
            if (r_a_done) begin
                r_last_moves <= r_a_moves;
                r_last_beats <= r_a_beats;
            end
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_chan    <= r_a_chan;
            r_o_frame   <= r_a_frame;
            r_o_collect <= r_a_collect;
            r_o_done    <= r_a_done;
        end
    end

    // Drive result ports
    assign o_out_valid       = r_out_valid;
    assign o_sampled_channel = r_o_chan;
    assign o_frame_index     = r_o_frame;
    assign o_collect_set     = r_o_collect;
    assign o_window_done     = r_o_done;
    assign o_sleep_stage     = r_stage;
    assign o_window_moves    = r_last_moves;
    assign o_window_beats    = r_last_beats;

    // ---------------- Assertions ----------------
    // Collect pulse only on the tick that wraps the channel
    a_collect_on_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_collect_set) |-> (o_sampled_channel == CHAN_LAST))
        else $error("collect set without channel wrap");

    // Frame index stays below the wrap value
    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_index < FRAME_WRAP_V))
        else $error("frame index out of range");

    // A blocked first stage keeps its transaction
    a_stage_a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !out_load) |=> (r_a_valid && $stable(r_a_beats)
                                      && $stable(r_a_done)))
        else $error("first stage lost a transaction");

    // Stage and baseline change only when a result is loaded
    a_stage_only_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_load |=> ($stable(r_stage) && $stable(r_baseline)))
        else $error("stage changed without a result load");

endmodule

`default_nettype wire
